### hdl/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg
// Shared constants and types of the common divisor enumerator.
// ----------------------------------------------------------------------------
package cde_pkg;

  localparam int FIELD_BITS   = 12;
  localparam int RESULT_LIMIT = 48;
  localparam int COUNT_BITS   = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_TEST  = 4'b0100,
    S_FLUSH = 4'b1000
  } trial_state_t;

endpackage

### hdl/common_divisor_enumerator.sv
// ----------------------------------------------------------------------------
// common_divisor_enumerator
// Emits every common divisor of an operand pair in ascending order.
// ----------------------------------------------------------------------------
// Input channel: item_valid / item_ready carry first_value and second_value;
// only the low VALUE_BITS bits of each are used. Give the same value twice
// to list the divisors of one number.
// Output channel: result_valid / result_ready carry divisor, zero_error and
// last_of_run. A pair gives one result per common divisor, smallest first,
// with last_of_run on the final one. A pair with a zero operand gives a
// single result with divisor 0, zero_error and last_of_run set.
// Every candidate from 1 up to the smaller operand passes through the
// bit-serial remainder unit (S_DIV), and both remainders are then tested
// for zero (S_TEST); a zero pair goes straight to S_FLUSH. One pair is
// worked on at a time, and the next is taken only from S_IDLE.
// The front accepts up to QUEUE_DEPTH + 1 further pairs while the engine
// runs. A stalled receiver holds the engine only when a divisor is due to
// move into the output register while the previous one still waits there.
// Reset empties the front stage and the queue, idles the engine and clears result_valid.
// ----------------------------------------------------------------------------
module common_divisor_enumerator #(
  parameter int VALUE_BITS  = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [cde_pkg::FIELD_BITS-1:0] first_value,
  input  logic [cde_pkg::FIELD_BITS-1:0] second_value,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [cde_pkg::FIELD_BITS-1:0] divisor,
  output logic                           zero_error,
  output logic                           last_of_run
);
  import cde_pkg::*;

  localparam int CMD_BITS = 3 * VALUE_BITS + 1;

  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;
  logic [VALUE_BITS-1:0] op_a;
  logic [VALUE_BITS-1:0] op_b;
  logic [VALUE_BITS-1:0] op_min;
  logic                  op_zero;
  logic [CMD_BITS-1:0]   wr_data;
  logic [CMD_BITS-1:0]   rd_data;

  assign wr_data = {op_a, op_b, op_min, op_zero};

  cde_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .first_value  (first_value),
    .second_value (second_value),
    .push         (push),
    .full         (full),
    .op_a         (op_a),
    .op_b         (op_b),
    .op_min       (op_min),
    .op_zero      (op_zero)
  );

  cde_fifo #(
    .WIDTH(CMD_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_data),
    .full    (full),
    .pop     (pop),
    .rd_data (rd_data),
    .empty   (empty)
  );

  cde_trial #(
    .VALUE_BITS(VALUE_BITS)
  ) u_trial (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop          (pop),
    .cmd_a        (rd_data[3*VALUE_BITS:2*VALUE_BITS+1]),
    .cmd_b        (rd_data[2*VALUE_BITS:VALUE_BITS+1]),
    .cmd_min      (rd_data[VALUE_BITS:1]),
    .cmd_zero     (rd_data[0]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .divisor      (divisor),
    .zero_error   (zero_error),
    .last_of_run  (last_of_run)
  );

endmodule

### hdl/cde_front.sv
// ----------------------------------------------------------------------------
// cde_front
// Accepts operand pairs, masks them, flags a zero operand and finds the
// smaller operand; holds the classified item until the queue takes it.
// ----------------------------------------------------------------------------
module cde_front #(
  parameter int VALUE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [cde_pkg::FIELD_BITS-1:0] first_value,
  input  logic [cde_pkg::FIELD_BITS-1:0] second_value,
  output logic                           push,
  input  logic                           full,
  output logic [VALUE_BITS-1:0]          op_a,
  output logic [VALUE_BITS-1:0]          op_b,
  output logic [VALUE_BITS-1:0]          op_min,
  output logic                           op_zero
);
  import cde_pkg::*;

  logic                  stage_valid;
  logic [VALUE_BITS-1:0] a_m;
  logic [VALUE_BITS-1:0] b_m;

  assign a_m        = first_value[VALUE_BITS-1:0];
  assign b_m        = second_value[VALUE_BITS-1:0];
  assign push       = stage_valid && !full;
  assign item_ready = !stage_valid || !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      op_a    <= a_m;
      op_b    <= b_m;
      op_min  <= (a_m < b_m) ? a_m : b_m;
      op_zero <= (a_m == '0) || (b_m == '0);
    end
  end

endmodule

### hdl/cde_fifo.sv
// ----------------------------------------------------------------------------
// cde_fifo
// Short queue of classified items between the front and the trial engine.
// ----------------------------------------------------------------------------
module cde_fifo #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import cde_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

### hdl/cde_trial.sv
// ----------------------------------------------------------------------------
// cde_trial
// Trial division engine: steps each candidate through a bit-serial remainder
// unit for both operands and emits common divisors through an output register.
// ----------------------------------------------------------------------------
module cde_trial #(
  parameter int VALUE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  output logic                           pop,
  input  logic [VALUE_BITS-1:0]          cmd_a,
  input  logic [VALUE_BITS-1:0]          cmd_b,
  input  logic [VALUE_BITS-1:0]          cmd_min,
  input  logic                           cmd_zero,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [cde_pkg::FIELD_BITS-1:0] divisor,
  output logic                           zero_error,
  output logic                           last_of_run
);
  import cde_pkg::*;

  localparam int SW = $clog2(VALUE_BITS);

  trial_state_t          state;
  logic [VALUE_BITS-1:0] held_a;
  logic [VALUE_BITS-1:0] held_b;
  logic [VALUE_BITS-1:0] limit;
  logic [VALUE_BITS-1:0] cand;
  logic [VALUE_BITS-1:0] sh_a;
  logic [VALUE_BITS-1:0] sh_b;
  logic [VALUE_BITS-1:0] rem_a;
  logic [VALUE_BITS-1:0] rem_b;
  logic [SW-1:0]         step;
  logic [COUNT_BITS-1:0] found;
  logic                  pend_valid;
  logic [VALUE_BITS-1:0] pend_div;
  logic                  pend_zero;

  logic [VALUE_BITS:0]   trial_a;
  logic [VALUE_BITS:0]   trial_b;
  logic [VALUE_BITS:0]   cand_x;
  logic [VALUE_BITS-1:0] rem_a_next;
  logic [VALUE_BITS-1:0] rem_b_next;
  logic                  slot_free;
  logic                  hit;
  logic                  advance;
  logic                  finish;
  logic                  load_out;

  assign cand_x     = {1'b0, cand};
  assign trial_a    = {rem_a, sh_a[VALUE_BITS-1]};
  assign trial_b    = {rem_b, sh_b[VALUE_BITS-1]};
  assign rem_a_next = (trial_a >= cand_x) ? VALUE_BITS'(trial_a - cand_x)
                                          : trial_a[VALUE_BITS-1:0];
  assign rem_b_next = (trial_b >= cand_x) ? VALUE_BITS'(trial_b - cand_x)
                                          : trial_b[VALUE_BITS-1:0];

  assign slot_free = !result_valid || result_ready;
  assign hit       = (rem_a == '0) && (rem_b == '0);
  assign advance   = !(hit && pend_valid) || slot_free;
  assign finish    = (hit && (found == COUNT_BITS'(RESULT_LIMIT - 1))) || (cand == limit);
  assign pop       = (state == S_IDLE) && !empty;
  assign load_out  = ((state == S_TEST) && hit && pend_valid && slot_free)
                  || ((state == S_FLUSH) && slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pend_valid   <= 1'b0;
      found        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            held_a <= cmd_a;
            held_b <= cmd_b;
            limit  <= cmd_min;
            found  <= '0;
            if (cmd_zero) begin
              pend_div   <= '0;
              pend_zero  <= 1'b1;
              pend_valid <= 1'b1;
              state      <= S_FLUSH;
            end else begin
              pend_zero  <= 1'b0;
              pend_valid <= 1'b0;
              cand       <= VALUE_BITS'(1);
              sh_a       <= cmd_a;
              sh_b       <= cmd_b;
              rem_a      <= '0;
              rem_b      <= '0;
              step       <= SW'(VALUE_BITS - 1);
              state      <= S_DIV;
            end
          end
        end
        S_DIV: begin
          sh_a  <= sh_a << 1;
          sh_b  <= sh_b << 1;
          rem_a <= rem_a_next;
          rem_b <= rem_b_next;
          step  <= step - 1'b1;
          if (step == '0) begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (advance) begin
            if (hit) begin
              pend_div   <= cand;
              pend_valid <= 1'b1;
              found      <= found + 1'b1;
            end
            if (finish) begin
              state <= S_FLUSH;
            end else begin
              cand  <= cand + 1'b1;
              sh_a  <= held_a;
              sh_b  <= held_b;
              rem_a <= '0;
              rem_b <= '0;
              step  <= SW'(VALUE_BITS - 1);
              state <= S_DIV;
            end
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (load_out) begin
      divisor     <= FIELD_BITS'(pend_div);
      zero_error  <= pend_zero;
      last_of_run <= (state == S_FLUSH);
    end
  end

endmodule

### hdl/cde_checker.sv
// ----------------------------------------------------------------------------
// cde_checker
// Port-level checks on the result channel of the common divisor enumerator.
// ----------------------------------------------------------------------------
module cde_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [cde_pkg::FIELD_BITS-1:0] divisor,
  input logic                           zero_error,
  input logic                           last_of_run
);
  import cde_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(divisor)
      && $stable(zero_error) && $stable(last_of_run))
    else $error("result item changed while stalled");

  a_zero_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_error |-> last_of_run && (divisor == '0))
    else $error("zero operand item must be a lone last item with divisor 0");

  a_nonzero_div: assert property (@(posedge clk) disable iff (rst)
    result_valid && !zero_error |-> (divisor != '0))
    else $error("divisor item carries zero");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind common_divisor_enumerator cde_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .divisor      (divisor),
  .zero_error   (zero_error),
  .last_of_run  (last_of_run)
);
